// File: src/asfe_pkg.sv
// Shared types and constants for the 8N1 receive deframer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package asfe_pkg;

    localparam int COUNT_W    = 6;
    localparam int FRAME_BITS = 10;

    // Kind of an input transaction (s_tuser)
    localparam logic REQ_BIT  = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef struct packed {
        logic load;   // shift the accepted item into the history
        logic trim;   // drop one idle bit at the old end
        logic emit;   // take one frame and write the output register
    } asfe_cmd_t;

    typedef struct packed {
        logic can_trim;  // ten or more bits held and the oldest is idle
        logic has_frame; // ten or more bits held and the oldest is a start bit
        logic out_free;  // output register can take a result this cycle
    } asfe_status_t;

endpackage

// File: src/asfe_datapath.sv
// Datapath: bit history shift register, valid bit count and output register.
// Depends on asfe_pkg; driven by asfe_controller.
`timescale 1ns / 1ps

module asfe_datapath
    import asfe_pkg::*;
#(
    parameter int HISTORY_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  asfe_cmd_t    cmd,
    output asfe_status_t status,
    input  logic         req_type,
    input  logic         line_bit,
    input  logic [7:0]   byte_bits,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   data_byte,
    output logic         frame_error
);

    localparam int IDX_W = $clog2(HISTORY_BITS);
    localparam int CAP   = (HISTORY_BITS < 63) ? HISTORY_BITS : 63;
    localparam logic [COUNT_W:0] CAP_V = (COUNT_W + 1)'(CAP);

    logic [HISTORY_BITS-1:0] history_reg, history_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              data_reg;
    logic                    error_reg;

    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] top_pos, data_pos, stop_pos;
    logic               ge_frame, top_bit, stop_bit;
    logic [7:0]         raw, rev;

    always_comb
    begin
        top_pos  = count_reg - COUNT_W'(1);
        data_pos = count_reg - COUNT_W'(FRAME_BITS - 1);
        stop_pos = count_reg - COUNT_W'(FRAME_BITS);
        ge_frame = count_reg >= COUNT_W'(FRAME_BITS);
        top_bit  = history_reg[top_pos[IDX_W-1:0]];
        stop_bit = history_reg[stop_pos[IDX_W-1:0]];
        raw      = 8'(history_reg >> data_pos[IDX_W-1:0]);
        for (int i = 0; i < 8; i++)
        begin
            rev[i] = raw[7-i];
        end
    end

    assign status.can_trim  = ge_frame & top_bit;
    assign status.has_frame = ge_frame & ~top_bit;
    assign status.out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        history_next   = history_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        count_sum      = {1'b0, count_reg} + ((req_type == REQ_BYTE) ? (COUNT_W + 1)'(8)
                                                                     : (COUNT_W + 1)'(1));
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            if (req_type == REQ_BYTE)
            begin
                history_next = {history_reg[HISTORY_BITS-9:0], byte_bits};
            end
            else
            begin
                history_next = {history_reg[HISTORY_BITS-2:0], line_bit};
            end
            count_next = (count_sum > CAP_V) ? CAP_V[COUNT_W-1:0] : count_sum[COUNT_W-1:0];
        end
        else if (cmd.trim)
        begin
            count_next = top_pos;
        end
        else if (cmd.emit)
        begin
            count_next     = stop_pos;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg   <= '1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            history_reg   <= history_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; a bad stop bit gives a zero byte
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            data_reg  <= stop_bit ? rev : 8'h00;
            error_reg <= ~stop_bit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = data_reg;
    assign frame_error = error_reg;

endmodule

// File: src/asfe_controller.sv
// Controller: accepts one input transaction, then trims idle bits and takes a frame if one is held.
// Depends on asfe_pkg; commands asfe_datapath.
`timescale 1ns / 1ps

module asfe_controller
    import asfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  asfe_status_t status,
    output asfe_cmd_t    cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                    ready_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (status.can_trim)
                begin
                    cmd.trim = 1'b1;
                end
                else if (status.has_frame)
                begin
                    // hold until the output register frees up
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                        ready_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// File: src/async_serial_frame_extractor_top.sv
// Top level of the 8N1 receive deframer: stream ports, controller and datapath.
// Depends on asfe_pkg, asfe_controller and asfe_datapath.
//
//  Channel   Direction  Payload
//  s_*       in         tdata: line_bit, byte_bits; tuser: req_type
//  m_*       out        tdata: data_byte; tuser: frame_error
//
// After an item is accepted, the scan state drops one idle bit per step at the
// old end of the history with the single shared trim step of the datapath.
// A frame waits in the scan state while the output register still holds an
// untaken result; s_tready is low from acceptance until the scan completes.
// Reset (rst_n low) fills the history with ones and clears the bit count.
`timescale 1ns / 1ps

module async_serial_frame_extractor_top
    import asfe_pkg::*;
#(
    parameter int HISTORY_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] line_bit, [8:1] byte_bits, [15:9] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [0:0]  m_tuser    // [0] frame_error
);

    asfe_cmd_t    cmd;
    asfe_status_t status;
    logic         frame_error;

    asfe_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asfe_datapath #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (s_tuser[0]),
        .line_bit    (s_tdata[0]),
        .byte_bits   (s_tdata[8:1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_byte   (m_tdata),
        .frame_error (frame_error)
    );

    assign m_tuser = frame_error;

endmodule

// File: test/async_serial_frame_extractor_top_tb.sv
// Self-checking testbench for the 8N1 receive deframer top level.
// Depends on asfe_pkg and async_serial_frame_extractor_top; drives line bits and bytes,
// predicts the received characters and checks each output transaction in order.
`timescale 1ns / 1ps

module async_serial_frame_extractor_top_tb;
    import asfe_pkg::*;

    localparam int HIST_BITS   = 32;
    localparam int COUNT_LIMIT = (HIST_BITS < 63) ? HIST_BITS : 63;
    localparam int RANDOM_ITEMS = 750;

    localparam int DRAIN_BYTES = 0;
    localparam int DRAIN_BITS  = 1;
    localparam int DRAIN_MIXED = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_error;
    } rx_char_t;

    // Tracks the line bit history and queues the characters it must produce.
    class rx_scoreboard;
        logic [HIST_BITS-1:0] line_history;
        int unsigned          held_bits;
        rx_char_t             expected_chars[$];
        int unsigned          mismatches;

        function new();
            line_history = '1;
            held_bits    = 0;
            mismatches   = 0;
        endfunction

        function void note_input(logic req, logic lb, logic [7:0] bb);
            rx_char_t   ch;
            logic [7:0] raw;
            if (req == REQ_BIT)
            begin
                line_history = {line_history[HIST_BITS-2:0], lb};
                held_bits    = held_bits + 1;
            end
            else
            begin
                line_history = {line_history[HIST_BITS-9:0], bb};
                held_bits    = held_bits + 8;
            end
            if (held_bits > COUNT_LIMIT)
                held_bits = COUNT_LIMIT;
            // drop idle bits at the old end
            while (held_bits >= FRAME_BITS && line_history[held_bits-1])
                held_bits = held_bits - 1;
            if (held_bits < FRAME_BITS)
                return;
            if (!line_history[held_bits-FRAME_BITS])
            begin
                ch.data_byte   = 8'h00;
                ch.frame_error = 1'b1;
            end
            else
            begin
                raw = line_history[held_bits-2 -: 8];
                for (int i = 0; i < 8; i++)
                    ch.data_byte[i] = raw[7-i];
                ch.frame_error = 1'b0;
            end
            held_bits = held_bits - FRAME_BITS;
            expected_chars.push_back(ch);
        endfunction

        function void check_result(logic [7:0] data, logic ferr);
            rx_char_t exp_ch;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character data_byte=%h frame_error=%b",
                         $time, data, ferr);
                mismatches++;
                return;
            end
            exp_ch = expected_chars.pop_front();
            if (data !== exp_ch.data_byte)
            begin
                $display("%0t: data_byte expected %h actual %h", $time, exp_ch.data_byte, data);
                mismatches++;
            end
            if (ferr !== exp_ch.frame_error)
            begin
                $display("%0t: frame_error expected %b actual %b",
                         $time, exp_ch.frame_error, ferr);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [0] line_bit, [8:1] byte_bits, [15:9] zero
    logic [0:0]  s_tuser  = '0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] data_byte
    logic [0:0]  m_tuser;         // [0] frame_error

    rx_scoreboard sb = new();
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           items_sent    = 0;
    bit           line_stream[$];

    async_serial_frame_extractor_top #(.HISTORY_BITS(HIST_BITS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // Present one transaction; return at the edge where it is accepted.
    task automatic send_item(input logic rt, input logic lb, input logic [7:0] bb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= {7'b0, bb, lb};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sb.note_input(rt, lb, bb);
        items_sent++;
    endtask

    task automatic append_frame(input logic [7:0] data, input bit stop, input int lead_idle);
        repeat (lead_idle) line_stream.push_back(1'b1);
        line_stream.push_back(1'b0);
        for (int i = 0; i < 8; i++)
            line_stream.push_back(data[i]);
        line_stream.push_back(stop);
    endtask

    // Feed the queued line bits as byte and bit transactions.
    task automatic drain_stream(input int mode);
        logic [7:0] octet;
        while (line_stream.size() > 0)
        begin
            if (line_stream.size() >= 8 &&
                (mode == DRAIN_BYTES || (mode == DRAIN_MIXED && $urandom_range(1) == 1)))
            begin
                for (int i = 0; i < 8; i++)
                    octet = {octet[6:0], line_stream.pop_front()};
                send_item(REQ_BYTE, $urandom_range(1), octet);
            end
            else
                send_item(REQ_BIT, line_stream.pop_front(), $urandom_range(255));
        end
    endtask

    task automatic random_phase(input int item_count);
        int target;
        target = items_sent + item_count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                // noise: arbitrary transaction, may break alignment
                send_item($urandom_range(1), $urandom_range(1), $urandom_range(255));
            end
            else
            begin
                append_frame($urandom_range(255), $urandom_range(9) != 0, $urandom_range(3));
                drain_stream($urandom_range(2));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle line with the unused field nonzero, then only idle bytes
        send_item(REQ_BIT, 1'b1, 8'hFF);
        send_item(REQ_BYTE, 1'b1, 8'hFF);
        send_item(REQ_BYTE, 1'b0, 8'hFF);
        // back-to-back frames: zero, all ones, a frame error, then two more
        append_frame(8'h00, 1'b1, 0);
        append_frame(8'hFF, 1'b1, 0);
        append_frame(8'h5A, 1'b0, 0);
        append_frame(8'h81, 1'b1, 0);
        append_frame(8'h3C, 1'b1, 0);
        repeat (6) line_stream.push_back(1'b1);
        drain_stream(DRAIN_BYTES);
        append_frame(8'h96, 1'b1, 1);
        drain_stream(DRAIN_BITS);

        random_phase(RANDOM_ITEMS / 4);
        send_idle_pct = 83;
        random_phase(RANDOM_ITEMS / 4);
        send_idle_pct = 0;
        stall_pct     = 83;
        random_phase(RANDOM_ITEMS / 4);
        send_idle_pct = 20;
        stall_pct     = 20;
        random_phase(RANDOM_ITEMS / 4);

        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: async_serial_frame_extractor_top.f
src/asfe_pkg.sv
src/asfe_datapath.sv
src/asfe_controller.sv
src/async_serial_frame_extractor_top.sv
test/async_serial_frame_extractor_top_tb.sv
